// ===== design/codon_usage_histogram_core_macros.svh =====
// ----------------------------------------------------------------------------
// codon usage histogram assertion macros
// concurrent checks clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef CODON_USAGE_HISTOGRAM_CORE_MACROS_SVH
`define CODON_USAGE_HISTOGRAM_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CUH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("codon usage histogram check failed");
// next-cycle implication
`define CUH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("codon usage histogram check failed");
`else
`define CUH_ASSERT_NOW(lbl, ante, cons)
`define CUH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/cuh_pkg.sv =====
// ----------------------------------------------------------------------------
// codon usage histogram package
// shared constants, opcodes, state type and counter memory request struct
// ----------------------------------------------------------------------------
package cuh_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int NUM_CODONS         = 64;
    localparam int CODON_AW           = 6;
    localparam int FIELD_BITS         = 32;

    // request opcodes
    localparam logic [1:0] KIND_NUC     = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_READOUT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RO_READ,
        ST_RO_LOAD,
        ST_RO_HOLD
    } cuh_state_t;

    typedef struct packed {
        logic                rd_en;
        logic                clr;
        logic [CODON_AW-1:0] rd_addr;
        logic                wr_en;
        logic [CODON_AW-1:0] wr_addr;
    } cuh_ram_req_t;

endpackage

// ===== design/cuh_count_ram.sv =====
// ----------------------------------------------------------------------------
// codon counter memory
// 64 counters, one read and one write port, registered read, per-entry
// valid bits so that reset clears the table at once and a readout read clears its entry
// ----------------------------------------------------------------------------
module cuh_count_ram
    import cuh_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cuh_ram_req_t          req,
    input  logic [COUNT_BITS-1:0] wr_data,
    output logic [COUNT_BITS-1:0] rd_data,
    output logic                  rd_hit
);

    logic [COUNT_BITS-1:0] mem [NUM_CODONS];
    logic [NUM_CODONS-1:0] valid_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // rd_hit flags whether the entry read was valid; the core reads an invalid entry as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.rd_en)
            begin
                rd_hit_reg <= valid_reg[req.rd_addr];
            end
            if (req.rd_en && req.clr)
            begin
                valid_reg[req.rd_addr] <= 1'b0;
            end
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_hit  = rd_hit_reg;

endmodule

// ===== design/codon_usage_histogram_core.sv =====
// update: a completed codon's counter is read when its last nucleotide is taken and written back in the next cycle
// throughput: one nucleotide or end-of-sequence request per cycle while idle; requests stall during a readout
// readout: 64 results, each through ST_RO_READ, ST_RO_LOAD and ST_RO_HOLD (held until out_ready),
//   paced by the single counter memory read port, its registered read and the output register
// reset: rst_n async low; counters clear at once through per-entry valid bits, no sweep
// ----------------------------------------------------------------------------
// codon usage histogram core
// frames nucleotides into codons, counts each of 64 codons and the codons
// holding an unknown symbol, and dumps and clears the table on request
// ----------------------------------------------------------------------------
`include "codon_usage_histogram_core_macros.svh"

module codon_usage_histogram_core
    import cuh_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            kind,
    input  logic [2:0]            base,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CODON_AW-1:0]   codon_index,
    output logic [FIELD_BITS-1:0] codon_count,
    output logic [FIELD_BITS-1:0] invalid_codons,
    output logic                  last
);

    // control
    cuh_state_t            state_reg, state_next;
    logic [CODON_AW-1:0]   ro_idx_reg;

    // reading frame
    logic [1:0]            phase_reg;
    logic [CODON_AW-1:0]   codon_reg;
    logic                  pinv_reg;
    logic [COUNT_BITS-1:0] inv_total_reg;

    // read-modify-write stage
    logic                  s1_valid_reg;
    logic [CODON_AW-1:0]   s1_addr_reg;
    logic [FIELD_BITS-1:0] out_count_reg;

    logic                  in_fire;
    logic                  nuc_fire;
    logic                  complete;
    logic                  cnt_fire;
    logic                  ro_start;
    logic                  out_fire;
    logic                  ro_done;
    logic [CODON_AW-1:0]   codon_w;
    logic                  inv_w;

    cuh_ram_req_t          ram_req;
    logic [COUNT_BITS-1:0] rd_data;
    logic                  rd_hit;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] inc_count;
    logic [COUNT_BITS-1:0] inv_inc;
    logic [FIELD_BITS-1:0] cur_clip;
    logic [FIELD_BITS-1:0] inv_clip;

    assign in_fire  = in_valid && in_ready;
    assign nuc_fire = in_fire && (kind == KIND_NUC);
    assign ro_start = in_fire && (kind == KIND_READOUT);
    assign complete = nuc_fire && (phase_reg == 2'd2);
    // shift the new base in, first base ends up most significant
    assign codon_w  = {codon_reg[CODON_AW-3:0], base[1:0]};
    assign inv_w    = pinv_reg || base[2];
    assign cnt_fire = complete && !inv_w;
    assign out_fire = out_valid && out_ready;
    assign last     = (ro_idx_reg == CODON_AW'(NUM_CODONS - 1));
    assign ro_done  = out_fire && last;

    // missing entries read as zero, counters saturate at all ones
    assign cur_count = rd_hit ? rd_data : '0;
    assign inc_count = (cur_count == '1) ? cur_count : cur_count + COUNT_BITS'(1);
    assign inv_inc   = (inv_total_reg == '1) ? inv_total_reg
                                             : inv_total_reg + COUNT_BITS'(1);

    // clip wide counts to the 32-bit result fields, zero-extend narrow ones
    generate
        if (COUNT_BITS > FIELD_BITS)
        begin : g_clip_wide
            assign cur_clip = (|cur_count[COUNT_BITS-1:FIELD_BITS]) ? '1
                                                                    : cur_count[FIELD_BITS-1:0];
            assign inv_clip = (|inv_total_reg[COUNT_BITS-1:FIELD_BITS]) ? '1
                                                                        : inv_total_reg[FIELD_BITS-1:0];
        end
        else if (COUNT_BITS == FIELD_BITS)
        begin : g_clip_same
            assign cur_clip = cur_count;
            assign inv_clip = inv_total_reg;
        end
        else
        begin : g_clip_narrow
            assign cur_clip = {{(FIELD_BITS-COUNT_BITS){1'b0}}, cur_count};
            assign inv_clip = {{(FIELD_BITS-COUNT_BITS){1'b0}}, inv_total_reg};
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ro_start)
                begin
                    state_next = ST_RO_READ;
                end
            end
            ST_RO_READ:
            begin
                state_next = ST_RO_LOAD;
            end
            ST_RO_LOAD:
            begin
                state_next = ST_RO_HOLD;
            end
            ST_RO_HOLD:
            begin
                if (out_ready)
                begin
                    state_next = last ? ST_IDLE : ST_RO_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and memory port selection
    always_comb
    begin
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        ram_req.rd_en   = cnt_fire;
        ram_req.clr     = 1'b0;
        ram_req.rd_addr = codon_w;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_RO_READ:
            begin
                // readout reads and clears one entry
                ram_req.rd_en   = 1'b1;
                ram_req.clr     = 1'b1;
                ram_req.rd_addr = ro_idx_reg;
            end
            ST_RO_LOAD:
            begin
            end
            ST_RO_HOLD:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
        // write back in the cycle after the codon read; a codon takes three
        // nucleotides, so no two updates of one entry overlap
        ram_req.wr_en   = s1_valid_reg;
        ram_req.wr_addr = s1_addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ro_idx_reg    <= '0;
            phase_reg     <= 2'd0;
            codon_reg     <= '0;
            pinv_reg      <= 1'b0;
            inv_total_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= cnt_fire;

            if (in_fire)
            begin
                case (kind)
                    KIND_NUC:
                    begin
                        if (phase_reg == 2'd2)
                        begin
                            phase_reg <= 2'd0;
                            codon_reg <= '0;
                            pinv_reg  <= 1'b0;
                            if (inv_w)
                            begin
                                inv_total_reg <= inv_inc;
                            end
                        end
                        else
                        begin
                            phase_reg <= phase_reg + 2'd1;
                            codon_reg <= codon_w;
                            pinv_reg  <= inv_w;
                        end
                    end
                    KIND_END:
                    begin
                        phase_reg <= 2'd0;
                        codon_reg <= '0;
                        pinv_reg  <= 1'b0;
                    end
                    KIND_READOUT:
                    begin
                        ro_idx_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (out_fire && !last)
            begin
                ro_idx_reg <= ro_idx_reg + CODON_AW'(1);
            end

            // invalid total clears once the final entry is taken
            if (ro_done)
            begin
                inv_total_reg <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cnt_fire)
        begin
            s1_addr_reg <= codon_w;
        end
        if (state_reg == ST_RO_LOAD)
        begin
            out_count_reg <= cur_clip;
        end
    end

    cuh_count_ram #(
        .COUNT_BITS (COUNT_BITS)
    ) u_count_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .wr_data (inc_count),
        .rd_data (rd_data),
        .rd_hit  (rd_hit)
    );

    assign codon_index    = ro_idx_reg;
    assign codon_count    = out_count_reg;
    assign invalid_codons = inv_clip;

    // no request is taken while a readout result is shown
    `CUH_ASSERT_NOW(a_no_request_in_readout, out_valid, !in_ready)
    // a pending counter write never meets a readout read
    `CUH_ASSERT_NOW(a_write_only_when_idle, s1_valid_reg, state_reg == ST_IDLE)
    // the final readout entry returns the block to taking requests and clears the invalid total
    `CUH_ASSERT_NEXT(a_idle_after_readout, ro_done, in_ready && invalid_codons == '0)
    // a completed valid codon is always written back next cycle
    `CUH_ASSERT_NEXT(a_codon_written, cnt_fire, ram_req.wr_en)

endmodule
